// ----- rtl/erbt_pkg.sv -----
// types, constants and codes shared by the exclusion region box test block
package erbt_pkg;

  // table geometry
  localparam int MAX_REGIONS = 64;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

  // coordinate formats, 4 fraction bits
  localparam int COORD_FRAC_BITS = 4;
  localparam int COORD_W         = 20;
  localparam int DBL_W           = COORD_W + 2;
  localparam int AP_W            = 16;
  localparam int MARGIN_W        = 12;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1 << COORD_FRAC_BITS);

  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_POINT_MARGIN = '0;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_RECT  = 2'd1,
    OP_POINT = 2'd2,
    OP_QUERY = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic signed [COORD_W-1:0]  x_a;
    logic signed [COORD_W-1:0]  y_a;
    logic signed [COORD_W-1:0]  x_b;
    logic signed [COORD_W-1:0]  y_b;
    logic [AP_W-1:0]            aperture;
  } in_item_t;

  typedef struct packed {
    logic             rejected;
    logic             table_full;
    logic [CNT_W-1:0] entry_count;
  } out_item_t;

  // one stored region, lower edges never above upper edges
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] bottom;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] top;
  } region_t;

  // star aperture box in doubled units
  typedef struct packed {
    logic signed [DBL_W-1:0] x_lo;
    logic signed [DBL_W-1:0] x_hi;
    logic signed [DBL_W-1:0] y_lo;
    logic signed [DBL_W-1:0] y_hi;
  } star_box_t;

  // classified command handed from front to back
  typedef struct packed {
    opcode_t   op;
    region_t   rect;
    star_box_t box;
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } back_state_t;

endpackage

// ----- rtl/erbt_front.sv -----
// front end: accepts items and turns them into ready-to-run commands
module erbt_front (
  input  erbt_pkg::in_item_t              in_item,
  input  logic [erbt_pkg::MARGIN_W-1:0]   point_margin,
  output erbt_pkg::cmd_t                  cmd
);
  import erbt_pkg::*;

  logic signed [COORD_W:0] margin_ext;
  logic signed [COORD_W:0] px_lo_w, px_hi_w, py_lo_w, py_hi_w;
  logic signed [DBL_W-1:0] x2, y2, ap_ext;
  region_t                 rect_region, point_region;

  // clamp a one-bit-wider value to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[COORD_W] != v[COORD_W-1]) begin
      r = v[COORD_W] ? COORD_MIN : COORD_MAX;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // rectangle with corners ordered per axis
  always_comb begin
    rect_region.left   = (in_item.x_a <= in_item.x_b) ? in_item.x_a : in_item.x_b;
    rect_region.right  = (in_item.x_a <= in_item.x_b) ? in_item.x_b : in_item.x_a;
    rect_region.bottom = (in_item.y_a <= in_item.y_b) ? in_item.y_a : in_item.y_b;
    rect_region.top    = (in_item.y_a <= in_item.y_b) ? in_item.y_b : in_item.y_a;
  end

  // square around a bad point, saturated
  assign margin_ext = $signed({{(COORD_W+1-MARGIN_W){1'b0}}, point_margin});
  assign px_lo_w = {in_item.x_a[COORD_W-1], in_item.x_a} - margin_ext;
  assign px_hi_w = {in_item.x_a[COORD_W-1], in_item.x_a} + margin_ext;
  assign py_lo_w = {in_item.y_a[COORD_W-1], in_item.y_a} - margin_ext;
  assign py_hi_w = {in_item.y_a[COORD_W-1], in_item.y_a} + margin_ext;

  always_comb begin
    point_region.left   = sat_coord(px_lo_w);
    point_region.right  = sat_coord(px_hi_w);
    point_region.bottom = sat_coord(py_lo_w);
    point_region.top    = sat_coord(py_hi_w);
  end

  // star box in doubled units, exact
  assign x2     = {in_item.x_a[COORD_W-1], in_item.x_a, 1'b0};
  assign y2     = {in_item.y_a[COORD_W-1], in_item.y_a, 1'b0};
  assign ap_ext = $signed({{(DBL_W-AP_W){1'b0}}, in_item.aperture});

  // command assembly
  always_comb begin
    cmd.op       = in_item.opcode;
    cmd.rect     = (in_item.opcode == OP_POINT) ? point_region : rect_region;
    cmd.box.x_lo = x2 - ap_ext;
    cmd.box.x_hi = x2 + ap_ext;
    cmd.box.y_lo = y2 - ap_ext;
    cmd.box.y_hi = y2 + ap_ext;
  end

endmodule

// ----- rtl/erbt_cmd_queue.sv -----
// short command queue between the front end and the table engine
module erbt_cmd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  erbt_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output erbt_pkg::cmd_t  head_cmd
);
  import erbt_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/erbt_back.sv -----
// table engine: region store, clear, insert and sequential overlap scan
module erbt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  erbt_pkg::cmd_t       cmd,
  output logic                 cmd_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output erbt_pkg::out_item_t  out_item
);
  import erbt_pkg::*;

  region_t           mem [MAX_REGIONS];
  region_t           rd_data_r;
  logic [IDX_W-1:0]  mem_raddr;
  logic              mem_we;

  back_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              out_valid_r;
  out_item_t         out_item_r;
  logic              res_load;
  out_item_t         res_item;

  logic              out_free;
  logic              table_full;
  logic              last_entry;
  logic              hit;
  logic signed [DBL_W-1:0] l2, b2, r2, t2;

  assign out_free   = !out_valid_r || out_ready;
  assign table_full = (count_r == CNT_W'(MAX_REGIONS));
  assign last_entry = ({1'b0, scan_idx_r} == (count_r - CNT_W'(1)));

  // inclusive overlap of star box against the entry just read
  assign l2  = {rd_data_r.left[COORD_W-1],   rd_data_r.left,   1'b0};
  assign b2  = {rd_data_r.bottom[COORD_W-1], rd_data_r.bottom, 1'b0};
  assign r2  = {rd_data_r.right[COORD_W-1],  rd_data_r.right,  1'b0};
  assign t2  = {rd_data_r.top[COORD_W-1],    rd_data_r.top,    1'b0};
  assign hit = (cmd.box.x_hi >= l2) && (cmd.box.y_hi >= b2) &&
               (cmd.box.x_lo <= r2) && (cmd.box.y_lo <= t2);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free && (cmd.op == OP_QUERY) && (count_r != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (out_free && (hit || last_entry)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control and result formation
  always_comb begin
    cmd_pop      = 1'b0;
    mem_we       = 1'b0;
    mem_raddr    = scan_idx_r;
    scan_idx_nxt = scan_idx_r;
    count_nxt    = count_r;
    res_load     = 1'b0;
    res_item     = '{rejected: 1'b0, table_full: 1'b0, entry_count: count_r};
    case (state_r)
      ST_IDLE: begin
        mem_raddr    = '0;
        scan_idx_nxt = '0;
        if (cmd_valid && out_free) begin
          case (cmd.op)
            OP_CLEAR: begin
              count_nxt            = '0;
              cmd_pop              = 1'b1;
              res_load             = 1'b1;
              res_item.entry_count = '0;
            end
            OP_RECT, OP_POINT: begin
              cmd_pop  = 1'b1;
              res_load = 1'b1;
              if (table_full) begin
                res_item.table_full = 1'b1;
              end else begin
                mem_we               = 1'b1;
                count_nxt            = count_r + 1'b1;
                res_item.entry_count = count_r + 1'b1;
              end
            end
            OP_QUERY: begin
              if (count_r == '0) begin
                cmd_pop  = 1'b1;
                res_load = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (out_free && (hit || last_entry)) begin
          cmd_pop           = 1'b1;
          res_load          = 1'b1;
          res_item.rejected = hit;
        end else if (!hit && !last_entry) begin
          mem_raddr    = scan_idx_r + 1'b1;
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      scan_idx_r <= scan_idx_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_item_r <= res_item;
    end
  end

  // region store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= cmd.rect;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/exclusion_region_box_test_core.sv -----
// top level of the exclusion region box test block
// Stores up to 64 image rectangles (signed 20-bit coordinates, 4 fraction
// bits) and tests star aperture boxes against them, edges inclusive. The
// front end takes one item per cycle while its two-entry command queue has
// room. The table engine runs clear and insert commands straight from its
// idle state; a query on a non-empty table enters a scan state that reads
// the stored regions one at a time, because the region memory has a single
// read port, and stops at the first overlapping region or after the last
// entry. Every item returns exactly one result, in order, through an output
// register. point_margin sits at byte address 0 of the configuration port
// and resets to 16 (one pixel).
module exclusion_region_box_test_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // item channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  erbt_pkg::in_item_t              in_item,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output erbt_pkg::out_item_t             out_item,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [erbt_pkg::PADDR_W-1:0]    paddr,
  input  logic [erbt_pkg::PDATA_W-1:0]    pwdata,
  output logic [erbt_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import erbt_pkg::*;

  logic [MARGIN_W-1:0]  point_margin_r;
  logic                 reg_sel;
  logic                 cfg_wr;
  cmd_t                 front_cmd;
  cmd_t                 head_cmd;
  logic                 q_full, q_not_empty, q_pop;

  // register decode
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_POINT_MARGIN);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? {{(PDATA_W-MARGIN_W){1'b0}}, point_margin_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_margin_r <= MARGIN_RESET;
    end else if (cfg_wr) begin
      point_margin_r <= pwdata[MARGIN_W-1:0];
    end
  end

  // item classification
  erbt_front u_front (
    .in_item      (in_item),
    .point_margin (point_margin_r),
    .cmd          (front_cmd)
  );

  assign in_ready = !q_full;

  // decoupling queue
  erbt_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // table engine
  erbt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- bench/testbench.sv -----
// self-checking testbench for the exclusion region box test block
`timescale 1ns / 1ps

module testbench;
  import erbt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 245;
  localparam logic [PADDR_W-1:0] MARGIN_ADDR = PADDR_W'(4 * int'(REG_POINT_MARGIN));

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready;
  out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // mirrored block state
  region_t excl_table [MAX_REGIONS];
  int unsigned excl_count;
  logic [MARGIN_W-1:0] margin_now;

  out_item_t pending_results[$];
  out_item_t want_result;
  int errors;
  int cycle_count;
  int send_idle_pct;
  int stall_pct;
  int hold_request;
  int hold_left;

  exclusion_region_box_test_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $realtime, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [COORD_W-1:0] clamp20(input longint v);
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    return COORD_W'(v);
  endfunction

  // result of one item, updating the mirrored table
  function automatic out_item_t box_test_result(input in_item_t it);
    out_item_t res;
    region_t nr;
    longint m;
    longint x2;
    longint y2;
    longint ap;
    logic signed [COORD_W-1:0] xl;
    logic signed [COORD_W-1:0] xh;
    logic signed [COORD_W-1:0] yl;
    logic signed [COORD_W-1:0] yh;
    res = '0;
    m = longint'(margin_now);
    case (it.opcode)
      OP_CLEAR: begin
        excl_count = 0;
      end
      OP_RECT, OP_POINT: begin
        if (it.opcode == OP_RECT) begin
          xl = it.x_a;
          yl = it.y_a;
          xh = it.x_b;
          yh = it.y_b;
        end else begin
          xl = clamp20(longint'($signed(it.x_a)) - m);
          yl = clamp20(longint'($signed(it.y_a)) - m);
          xh = clamp20(longint'($signed(it.x_a)) + m);
          yh = clamp20(longint'($signed(it.y_a)) + m);
        end
        if (excl_count >= MAX_REGIONS) begin
          res.table_full = 1'b1;
        end else begin
          nr.left   = (xl <= xh) ? xl : xh;
          nr.right  = (xl <= xh) ? xh : xl;
          nr.bottom = (yl <= yh) ? yl : yh;
          nr.top    = (yl <= yh) ? yh : yl;
          excl_table[excl_count] = nr;
          excl_count++;
        end
      end
      default: begin
        // doubled coordinates, edges inclusive
        x2 = 2 * longint'($signed(it.x_a));
        y2 = 2 * longint'($signed(it.y_a));
        ap = longint'(it.aperture);
        for (int i = 0; i < excl_count; i++) begin
          if (x2 + ap >= 2 * longint'($signed(excl_table[i].left)) &&
              y2 + ap >= 2 * longint'($signed(excl_table[i].bottom)) &&
              x2 - ap <= 2 * longint'($signed(excl_table[i].right)) &&
              y2 - ap <= 2 * longint'($signed(excl_table[i].top)))
            res.rejected = 1'b1;
        end
      end
    endcase
    res.entry_count = CNT_W'(excl_count);
    return res;
  endfunction

  function automatic in_item_t make_item(input opcode_t op, input int xa, input int ya,
                                         input int xb, input int yb, input int ap);
    in_item_t it;
    it.opcode   = op;
    it.x_a      = COORD_W'(xa);
    it.y_a      = COORD_W'(ya);
    it.x_b      = COORD_W'(xb);
    it.y_b      = COORD_W'(yb);
    it.aperture = AP_W'(ap);
    return it;
  endfunction

  // mostly well-formed traffic: inserts, queries aimed at stored edges, some noise
  function automatic in_item_t random_item();
    in_item_t it;
    region_t r;
    int pick;
    int side;
    int ap;
    int d;
    longint cx;
    longint cy;
    longint lo;
    longint hi;
    it.opcode   = opcode_t'($urandom_range(3));
    it.x_a      = COORD_W'($urandom);
    it.y_a      = COORD_W'($urandom);
    it.x_b      = COORD_W'($urandom);
    it.y_b      = COORD_W'($urandom);
    it.aperture = AP_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) return it;
    if (pick < 15) begin
      it.opcode = OP_CLEAR;
    end else if (pick < 55 || excl_count == 0) begin
      if ($urandom_range(1) == 0) begin
        it.opcode = OP_POINT;
      end else begin
        it.opcode = OP_RECT;
        // small rectangles mostly, so queries can miss
        if ($urandom_range(3) != 0) begin
          cx = longint'($signed(it.x_a));
          cy = longint'($signed(it.y_a));
          it.x_b = clamp20(cx + $urandom_range(4000) - 2000);
          it.y_b = clamp20(cy + $urandom_range(4000) - 2000);
        end
      end
    end else begin
      it.opcode = OP_QUERY;
      r = excl_table[$urandom_range(excl_count - 1)];
      ap = $urandom_range(255);
      d = $urandom_range(2) - 1;
      side = $urandom_range(4);
      it.aperture = AP_W'(ap);
      lo = longint'($signed(r.left));
      hi = longint'($signed(r.right));
      it.x_a = clamp20(lo + longint'($urandom_range(int'(hi - lo))));
      lo = longint'($signed(r.bottom));
      hi = longint'($signed(r.top));
      it.y_a = clamp20(lo + longint'($urandom_range(int'(hi - lo))));
      case (side)
        1: it.x_a = clamp20(longint'($signed(r.left)) - ap / 2 + d);
        2: it.x_a = clamp20(longint'($signed(r.right)) + ap / 2 + d);
        3: it.y_a = clamp20(longint'($signed(r.bottom)) - ap / 2 + d);
        4: it.y_a = clamp20(longint'($signed(r.top)) + ap / 2 + d);
        default: ;
      endcase
    end
    return it;
  endfunction

  // offer one item and record its expected result on acceptance
  task automatic offer_item(input in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(box_test_result(it));
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write point_margin, then read it back
  task automatic write_margin(input logic [MARGIN_W-1:0] value);
    logic [PDATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MARGIN_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    margin_now = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[MARGIN_W-1:0] !== value) begin
      $display("%0t: point_margin readback expected %0d actual %0d",
               $realtime, value, readback[MARGIN_W-1:0]);
      errors++;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $realtime, out_item);
        errors++;
      end else begin
        want_result = pending_results.pop_front();
        check_field("rejected", want_result.rejected, out_item.rejected);
        check_field("table_full", want_result.table_full, out_item.table_full);
        check_field("entry_count", want_result.entry_count, out_item.entry_count);
      end
    end
  end

  // result side ready, with random stalls and a counted hold-off
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    <= hold_request;
      hold_request <= 0;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // edges, corner ordering, saturation with the reset margin, clear
  task automatic test_directed();
    send_idle_pct = 30;
    stall_pct = 30;
    offer_item(make_item(OP_QUERY, 524287, -524288, 0, 0, 65535));
    offer_item(make_item(OP_RECT, 300, 200, -100, -50, 65535));
    offer_item(make_item(OP_QUERY, -104, 0, -5, 7, 8));
    offer_item(make_item(OP_QUERY, -104, 0, 0, 0, 7));
    offer_item(make_item(OP_QUERY, 0, 204, 0, 0, 8));
    offer_item(make_item(OP_QUERY, 0, 204, 0, 0, 7));
    offer_item(make_item(OP_QUERY, 304, 0, 0, 0, 8));
    offer_item(make_item(OP_QUERY, 0, -54, 0, 0, 7));
    offer_item(make_item(OP_POINT, -524288, -524288, 524287, -1, 65535));
    offer_item(make_item(OP_POINT, 524287, 524287, -524288, 0, 0));
    offer_item(make_item(OP_QUERY, -524288, -524288, 0, 0, 0));
    offer_item(make_item(OP_QUERY, 524287, 524287, 0, 0, 0));
    offer_item(make_item(OP_QUERY, 524270, 524270, 0, 0, 0));
    offer_item(make_item(OP_CLEAR, -1, -1, -1, -1, 65535));
    offer_item(make_item(OP_QUERY, 0, 0, 0, 0, 65535));
    offer_item(make_item(OP_RECT, 5000, 6000, 5000, 6000, 0));
    offer_item(make_item(OP_QUERY, 5000, 6000, 0, 0, 0));
    offer_item(make_item(OP_QUERY, 5001, 6000, 0, 0, 1));
    offer_item(make_item(OP_QUERY, 5001, 6000, 0, 0, 2));
    offer_item(make_item(OP_RECT, 524287, -524288, -524288, 524287, 0));
    offer_item(make_item(OP_QUERY, -524288, 524287, 0, 0, 0));
    offer_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
    wait_results_done();
  endtask

  // margin extremes and saturation of the excluded square
  task automatic test_point_margin();
    write_margin('0);
    offer_item(make_item(OP_POINT, 1000, 1000, 0, 0, 0));
    offer_item(make_item(OP_QUERY, 1000, 1000, 0, 0, 0));
    offer_item(make_item(OP_QUERY, 1001, 1000, 0, 0, 1));
    offer_item(make_item(OP_QUERY, 1001, 1000, 0, 0, 2));
    wait_results_done();
    write_margin({MARGIN_W{1'b1}});
    offer_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
    offer_item(make_item(OP_POINT, 524000, -524000, 0, 0, 0));
    offer_item(make_item(OP_QUERY, 524287, -524288, 0, 0, 0));
    offer_item(make_item(OP_QUERY, 519905, -524000, 0, 0, 0));
    offer_item(make_item(OP_QUERY, 519904, -524000, 0, 0, 0));
    offer_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
    wait_results_done();
  endtask

  // fill the table, then inserts are refused
  task automatic test_full_table();
    send_idle_pct = 0;
    stall_pct = 0;
    offer_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
    while (excl_count < MAX_REGIONS) begin
      offer_item(make_item(OP_RECT, $urandom_range(2000), $urandom_range(2000),
                           $urandom_range(2000), $urandom_range(2000), 0));
    end
    offer_item(make_item(OP_RECT, 10, 10, 20, 20, 0));
    offer_item(make_item(OP_POINT, 0, 0, 0, 0, 0));
    offer_item(make_item(OP_QUERY, -10000, -10000, 0, 0, 3));
    offer_item(make_item(OP_QUERY, 1000, 1000, 0, 0, 0));
    wait_results_done();
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request <= 400;
    repeat (30) offer_item(random_item());
    wait_results_done();
  endtask

  task automatic test_random_phase(input int idle, input int stall,
                                   input logic [MARGIN_W-1:0] margin);
    write_margin(margin);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (PHASE_ITEMS) offer_item(random_item());
    wait_results_done();
  endtask

  initial begin
    errors = 0;
    cycle_count = 0;
    excl_count = 0;
    margin_now = MARGIN_RESET;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    rst_n   <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_point_margin();
    test_full_table();
    test_backpressure();
    test_random_phase(0, 0, MARGIN_RESET);
    test_random_phase(63, 0, {MARGIN_W{1'b1}});
    test_random_phase(0, 63, '0);
    test_random_phase(7, 7, MARGIN_W'($urandom));

    // let any stray result show up
    wait_results_done();
    repeat (80) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/erbt_pkg.sv
rtl/erbt_front.sv
rtl/erbt_cmd_queue.sv
rtl/erbt_back.sv
rtl/exclusion_region_box_test_core.sv
bench/testbench.sv
